// File: sv/zcdp_pkg.sv
// Package for the ZIP central directory parser core.
// Holds result kind codes, record layout offsets and the result bus packing.
// No dependencies.
`default_nettype none

package zcdp_pkg;

    typedef logic [1:0]  t_kind;
    typedef logic [17:0] t_pos;

    localparam t_kind KIND_NAME = 2'd0;
    localparam t_kind KIND_DESC = 2'd1;
    localparam t_kind KIND_DONE = 2'd2;

    localparam logic [31:0] CD_SIG = 32'h02014b50;

    localparam t_pos POS_SIG_END   = 18'd3;
    localparam t_pos POS_METHOD    = 18'd10;
    localparam t_pos POS_CRC       = 18'd16;
    localparam t_pos POS_PACKED    = 18'd20;
    localparam t_pos POS_PLAIN     = 18'd24;
    localparam t_pos POS_NAME_LEN  = 18'd28;
    localparam t_pos POS_EXTRA_LEN = 18'd30;
    localparam t_pos POS_COMM_LEN  = 18'd32;
    localparam t_pos POS_OFFSET    = 18'd42;
    localparam t_pos FIXED_LEN     = 18'd46;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 192;
    localparam int CFG_W       = 16;

    localparam int O_NAME_CHAR = 0;
    localparam int O_METHOD    = 8;
    localparam int O_CRC       = 24;
    localparam int O_PACKED    = 56;
    localparam int O_PLAIN     = 88;
    localparam int O_OFFSET    = 120;
    localparam int O_NAME_LEN  = 152;
    localparam int O_INDEX     = 168;
    localparam int O_EARLY     = 184;

endpackage

`default_nettype wire

// File: sv/zip_central_directory_parser_core.sv
// Top level of the ZIP central directory parser: byte-wise record parsing.
// Depends on zcdp_pkg for kind codes, record offsets and result packing.
//
// Channel   Dir  Payload
// s_axis    in   tdata[7:0] dir_byte, tuser start_flag, tlast end_flag
// m_axis    out  tdata (see port), tuser kind, tlast last_of_run
// cfg       in   i_cfg_data entry_count
//
// One byte is parsed per cycle between the input register and the result
// register; a byte enters every cycle while each byte yields at most one result
// and m_axis is ready. A byte yielding two or three results holds the next byte
// until one result is left; the result register sends one result per ready cycle.
// While a result waits on a stalled m_axis, the input register takes one more
// byte and then holds s_axis_tready low.
// Reset clears all parse state; no clearing pass is needed.
`default_nettype none

module zip_central_directory_parser_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // dir_byte[7:0]
    input  wire logic [zcdp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // start_flag
    input  wire logic                              s_axis_tuser,
    input  wire logic                              s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // name_char[7:0], method[23:8], crc_value[55:24], packed_size[87:56],
    // plain_size[119:88], header_offset[151:120], name_length[167:152],
    // entry_index[183:168], stopped_early[184], zero[191:185]
    output logic [zcdp_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // kind[1:0]
    output logic [1:0]                             m_axis_tuser,
    output logic                                   m_axis_tlast,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [zcdp_pkg::CFG_W-1:0]        i_cfg_data
);
    import zcdp_pkg::*;

    logic [15:0] r_entry_count;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_start;
    logic        r_in_last;

    t_pos        r_pos,  n_pos,  e_pos;
    logic [15:0] r_meth, n_meth, e_meth;
    logic [31:0] r_crc,  n_crc,  e_crc;
    logic [31:0] r_pk,   n_pk,   e_pk;
    logic [31:0] r_pl,   n_pl,   e_pl;
    logic [15:0] r_nl,   n_nl,   e_nl;
    logic [15:0] r_el,   n_el,   e_el;
    logic [15:0] r_cl,   n_cl,   e_cl;
    logic [31:0] r_off,  n_off,  e_off;
    logic [31:0] r_sig,  n_sig,  e_sig;
    logic [15:0] r_ed,   n_ed,   e_ed;
    logic        r_fin,  n_fin,  e_fin;

    logic        f_name, f_desc, f_done, f_early;
    logic [15:0] f_done_idx;
    t_pos        total;

    logic        r_b_name, r_b_desc, r_b_done;
    logic [7:0]  r_b_char;
    logic [15:0] r_b_meth, r_b_nl, r_b_idx, r_b_done_idx;
    logic [31:0] r_b_crc, r_b_pk, r_b_pl, r_b_off;
    logic        r_b_early;

    logic        m_hs;
    logic        b_single;
    logic        move;

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_b_name | r_b_desc | r_b_done;
    assign m_hs          = m_axis_tvalid & m_axis_tready;
    assign b_single      = $countones({r_b_name, r_b_desc, r_b_done}) == 1;
    assign move          = r_in_valid & (!m_axis_tvalid | (b_single & m_axis_tready));
    assign s_axis_tready = !r_in_valid | move;
    assign m_axis_tlast  = b_single;

    always_comb begin
        e_pos  = r_in_start ? '0 : r_pos;
        e_meth = r_in_start ? '0 : r_meth;
        e_crc  = r_in_start ? '0 : r_crc;
        e_pk   = r_in_start ? '0 : r_pk;
        e_pl   = r_in_start ? '0 : r_pl;
        e_nl   = r_in_start ? '0 : r_nl;
        e_el   = r_in_start ? '0 : r_el;
        e_cl   = r_in_start ? '0 : r_cl;
        e_off  = r_in_start ? '0 : r_off;
        e_sig  = r_in_start ? '0 : r_sig;
        e_ed   = r_in_start ? '0 : r_ed;
        e_fin  = r_in_start ? 1'b0 : r_fin;

        n_pos = e_pos;  n_meth = e_meth; n_crc = e_crc; n_pk  = e_pk;
        n_pl  = e_pl;   n_nl   = e_nl;   n_el  = e_el;  n_cl  = e_cl;
        n_off = e_off;  n_sig  = e_sig;  n_ed  = e_ed;  n_fin = e_fin;

        f_name     = 1'b0;
        f_desc     = 1'b0;
        f_done     = 1'b0;
        f_early    = 1'b0;
        f_done_idx = e_ed;
        total      = '0;

        if (!e_fin) begin
            if (e_pos == '0 && e_ed >= r_entry_count) begin
                f_done = 1'b1;
                n_fin  = 1'b1;
            end else begin
                if (e_pos <= POS_SIG_END) begin
                    n_sig = {r_in_byte, e_sig[31:8]};
                end else if (e_pos == POS_METHOD || e_pos == POS_METHOD + 18'd1) begin
                    n_meth = {r_in_byte, e_meth[15:8]};
                end else if (e_pos >= POS_CRC && e_pos < POS_PACKED) begin
                    n_crc = {r_in_byte, e_crc[31:8]};
                end else if (e_pos >= POS_PACKED && e_pos < POS_PLAIN) begin
                    n_pk = {r_in_byte, e_pk[31:8]};
                end else if (e_pos >= POS_PLAIN && e_pos < POS_NAME_LEN) begin
                    n_pl = {r_in_byte, e_pl[31:8]};
                end else if (e_pos == POS_NAME_LEN || e_pos == POS_NAME_LEN + 18'd1) begin
                    n_nl = {r_in_byte, e_nl[15:8]};
                end else if (e_pos == POS_EXTRA_LEN || e_pos == POS_EXTRA_LEN + 18'd1) begin
                    n_el = {r_in_byte, e_el[15:8]};
                end else if (e_pos == POS_COMM_LEN || e_pos == POS_COMM_LEN + 18'd1) begin
                    n_cl = {r_in_byte, e_cl[15:8]};
                end else if (e_pos >= POS_OFFSET && e_pos < FIXED_LEN) begin
                    n_off = {r_in_byte, e_off[31:8]};
                end

                if (e_pos == POS_SIG_END && n_sig != CD_SIG) begin
                    f_done  = 1'b1;
                    f_early = 1'b1;
                    n_fin   = 1'b1;
                end else begin
                    if (e_pos >= FIXED_LEN && (e_pos - FIXED_LEN) < {2'b00, n_nl}) begin
                        f_name = 1'b1;
                    end
                    total = FIXED_LEN + {2'b00, n_nl} + {2'b00, n_el} + {2'b00, n_cl};
                    if (e_pos >= FIXED_LEN - 18'd1 && e_pos == total - 18'd1) begin
                        f_desc = 1'b1;
                        n_ed   = e_ed + 16'd1;
                        n_pos  = '0;
                        if (n_ed >= r_entry_count) begin
                            f_done     = 1'b1;
                            n_fin      = 1'b1;
                            f_done_idx = n_ed;
                        end
                    end else begin
                        n_pos = e_pos + 18'd1;
                    end
                end
            end

            if (r_in_last && !n_fin) begin
                f_done     = 1'b1;
                f_early    = 1'b1;
                n_fin      = 1'b1;
                f_done_idx = n_ed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_in_valid    <= 1'b0;
            r_pos  <= '0; r_meth <= '0; r_crc <= '0; r_pk  <= '0;
            r_pl   <= '0; r_nl   <= '0; r_el  <= '0; r_cl  <= '0;
            r_off  <= '0; r_sig  <= '0; r_ed  <= '0; r_fin <= 1'b0;
            r_b_name <= 1'b0;
            r_b_desc <= 1'b0;
            r_b_done <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_entry_count <= i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_pos  <= n_pos;  r_meth <= n_meth; r_crc <= n_crc; r_pk  <= n_pk;
                r_pl   <= n_pl;   r_nl   <= n_nl;   r_el  <= n_el;  r_cl  <= n_cl;
                r_off  <= n_off;  r_sig  <= n_sig;  r_ed  <= n_ed;  r_fin <= n_fin;
                r_b_name <= f_name;
                r_b_desc <= f_desc;
                r_b_done <= f_done;
            end else if (m_hs) begin
                if (r_b_name) begin
                    r_b_name <= 1'b0;
                end else if (r_b_desc) begin
                    r_b_desc <= 1'b0;
                end else begin
                    r_b_done <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte  <= s_axis_tdata[7:0];
            r_in_start <= s_axis_tuser;
            r_in_last  <= s_axis_tlast;
        end
        if (move) begin
            r_b_char     <= r_in_byte;
            r_b_meth     <= n_meth;
            r_b_crc      <= n_crc;
            r_b_pk       <= n_pk;
            r_b_pl       <= n_pl;
            r_b_off      <= n_off;
            r_b_nl       <= n_nl;
            r_b_idx      <= e_ed;
            r_b_done_idx <= f_done_idx;
            r_b_early    <= f_early;
        end
    end

    always_comb begin
        m_axis_tdata = '0;
        if (r_b_name) begin
            m_axis_tuser = KIND_NAME;
            m_axis_tdata[O_NAME_CHAR +: 8] = r_b_char;
            m_axis_tdata[O_INDEX +: 16]    = r_b_idx;
        end else if (r_b_desc) begin
            m_axis_tuser = KIND_DESC;
            m_axis_tdata[O_METHOD +: 16]   = r_b_meth;
            m_axis_tdata[O_CRC +: 32]      = r_b_crc;
            m_axis_tdata[O_PACKED +: 32]   = r_b_pk;
            m_axis_tdata[O_PLAIN +: 32]    = r_b_pl;
            m_axis_tdata[O_OFFSET +: 32]   = r_b_off;
            m_axis_tdata[O_NAME_LEN +: 16] = r_b_nl;
            m_axis_tdata[O_INDEX +: 16]    = r_b_idx;
        end else begin
            m_axis_tuser = KIND_DONE;
            m_axis_tdata[O_INDEX +: 16]    = r_b_done_idx;
            m_axis_tdata[O_EARLY]          = r_b_early;
        end
    end

`ifndef SYNTH
    a_done_implies_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_done |-> r_fin)
        else $error("done result pending without finished state");

    a_finished_holds_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin && !(move && r_in_start) |=> $stable(r_ed) && $stable(r_pos))
        else $error("parse state moved after finishing");

    a_normal_done_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_done && !r_b_name && !r_b_desc && !r_b_early |-> r_b_done_idx >= r_entry_count)
        else $error("normal done before entry count reached");
`endif

endmodule

`default_nettype wire
